// File: rtl/stillness_segmented_joint_features_assert.svh
// Assertion macros for the checker module of this block
`ifndef STILLNESS_SEGMENTED_JOINT_FEATURES_ASSERT_SVH
`define STILLNESS_SEGMENTED_JOINT_FEATURES_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SSJF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssjf assertion failed");

// Next-cycle implication, disabled while in reset
`define SSJF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssjf assertion failed");

`endif

// File: rtl/ssjf_pkg.sv
// Package: shared constants and the arctangent table for the feature extractor
package ssjf_pkg;

  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;

  // atan(2^-i) in Q30, rounded; beyond the table it equals 2^(30-i)
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd843314857;
      5'd1:    v = 32'd497837830;
      5'd2:    v = 32'd263043837;
      5'd3:    v = 32'd133525159;
      5'd4:    v = 32'd67021687;
      5'd5:    v = 32'd33543516;
      5'd6:    v = 32'd16775851;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194283;
      5'd9:    v = 32'd2097149;
      5'd10:   v = 32'd1048576;
      default: v = 32'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// File: rtl/stillness_segmented_joint_features.sv
// Top level: stillness-segmented joint distance and angle extractor
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------------
// in      | into      | in_valid / in_ready  | twelve joint coordinates
// out     | out of    | out_valid/out_ready  | four distances, four angles, index, end
// cfg     | into      | cfg_we               | cfg_index, cfg_data
//
// Every frame makes a stillness pass over its twelve coordinates through the shared
// multiplier, then a decision state; a frame with no result is then done.
// A captured frame adds per joint a multiply pass over its three coordinates, two passes
// of the bit-pair square root (distance, then horizontal) and a CORDIC vectoring.
// Reset is synchronous and clears control state and the previous positions.
// A result waits in the output register; the next frame is taken meanwhile, and only
// the final transfer of a further result stalls on out_ready.
module stillness_segmented_joint_features #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [14:0] left_hand_x,
  input  logic [14:0] left_hand_y,
  input  logic [14:0] left_hand_z,
  input  logic [14:0] left_elbow_x,
  input  logic [14:0] left_elbow_y,
  input  logic [14:0] left_elbow_z,
  input  logic [14:0] right_hand_x,
  input  logic [14:0] right_hand_y,
  input  logic [14:0] right_hand_z,
  input  logic [14:0] right_elbow_x,
  input  logic [14:0] right_elbow_y,
  input  logic [14:0] right_elbow_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] left_hand_distance,
  output logic [15:0] left_elbow_distance,
  output logic [15:0] right_hand_distance,
  output logic [15:0] right_elbow_distance,
  output logic [14:0] left_hand_angle,
  output logic [14:0] left_elbow_angle,
  output logic [14:0] right_hand_angle,
  output logic [14:0] right_elbow_angle,
  output logic [15:0] observation_index,
  output logic        gesture_end
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int SQW = 2 * CW;
  localparam int HW  = 2 * CW + 1;
  localparam int SW  = 2 * CW + 2;
  localparam int RW  = CW + 13;
  localparam int QW  = 2 * RW;
  localparam int XW  = CW + 16;
  localparam int ZW  = ssjf_pkg::ZW;
  localparam int SH  = 30 - ANGLE_FRAC_BITS;
  localparam int RCW = $clog2(RW + 1);
  localparam logic signed [ZW-1:0] RND = ZW'(64'sd1 <<< (29 - ANGLE_FRAC_BITS));
  localparam longint AMAX = (64'sd3373259426 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> SH;
  localparam logic signed [ZW-1:0] AMAX_CL = (AMAX > 32767) ? ZW'(32767) : ZW'(AMAX);
  localparam logic signed [24:0] CHI = 25'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [24:0] CLO = -CHI - 25'sd1;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_STILL     = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ST_MUL = 11'b000_0000_0010,
    S_ST_ACC = 11'b000_0000_0100,
    S_DECIDE = 11'b000_0000_1000,
    S_FE_MUL = 11'b000_0001_0000,
    S_FE_ACC = 11'b000_0010_0000,
    S_RT_D   = 11'b000_0100_0000,
    S_RT_H   = 11'b000_1000_0000,
    S_CORDIC = 11'b001_0000_0000,
    S_ANG    = 11'b010_0000_0000,
    S_PUSH   = 11'b100_0000_0000
  } state_t;

  function automatic logic signed [CW-1:0] sat_coord(input logic [14:0] v);
    logic signed [24:0] e;
    e = 25'(signed'(v));
    if (e > CHI) begin
      e = CHI;
    end else if (e < CLO) begin
      e = CLO;
    end
    return e[CW-1:0];
  endfunction

  state_t state;
  logic signed [CW-1:0] cur [12];
  logic signed [CW-1:0] prev [12];
  logic signed [CW-1:0] start [12];
  logic [9:0]  thr;
  logic [19:0] thr2;
  logic [7:0]  still_frames;
  logic [7:0]  still_count;
  logic        capturing;
  logic [15:0] obs;
  logic        still_all;
  logic [1:0]  k;
  logic [1:0]  j;
  logic [SQW-1:0] prod;
  logic [HW-1:0]  acc_h;
  logic [SQW-1:0] dysq;
  logic signed [DW-1:0] dcur;
  logic signed [DW-1:0] dy_r;
  logic [HW-1:0]  h2_r;
  logic [QW-1:0]  opnd;
  logic [RW+1:0]  rem;
  logic [RW-1:0]  root;
  logic [RCW-1:0] rcnt;
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;
  logic signed [ZW-1:0] cz;
  logic [4:0] it;
  logic [15:0] dist_r [4];
  logic [14:0] ang_r [4];
  logic [15:0] idx_r;
  logic        end_r;
  logic [15:0] od [4];
  logic [14:0] oa [4];

  // datapath helpers
  logic signed [DW-1:0]   d_sel;
  logic signed [2*DW-1:0] sq_full;
  logic [SW-1:0]  sum_s;
  logic [HW-1:0]  h2_nx;
  logic [RW+2:0]  rem_sh;
  logic [RW+2:0]  trial;
  logic [RW+2:0]  rem_sub;
  logic [RW-1:0]  root_nx;
  logic [RW+1:0]  rem_nx;
  logic [15:0]    dist_sat;
  logic signed [XW-1:0] dyx;
  logic signed [XW-1:0] hx;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] at;
  logic signed [ZW-1:0] rr;
  logic signed [ZW-1:0] rs;
  logic [14:0]  ang_fin;
  logic [7:0]   run_len;
  logic [7:0]   sc_inc;
  logic         hit;
  logic [15:0]  obs_nx;

  always_comb begin
    // difference against previous or start position, and its square
    if (state == S_ST_MUL) begin
      d_sel = DW'(cur[0]) - DW'(prev[0]);
    end else begin
      d_sel = DW'(cur[0]) - DW'(start[0]);
    end
    sq_full = d_sel * d_sel;
    sum_s   = SW'(acc_h) + SW'(prod) + SW'(dysq);
    h2_nx   = acc_h + HW'(prod);

    // one root digit
    rem_sh  = {rem[RW:0], opnd[QW-1:QW-2]};
    trial   = {1'b0, root, 2'b01};
    rem_sub = rem_sh - trial;
    if (rem_sh >= trial) begin
      rem_nx  = rem_sub[RW+1:0];
      root_nx = {root[RW-2:0], 1'b1};
    end else begin
      rem_nx  = rem_sh[RW+1:0];
      root_nx = {root[RW-2:0], 1'b0};
    end
    dist_sat = (root_nx > RW'(16'hFFFF)) ? 16'hFFFF : root_nx[15:0];

    // CORDIC operands
    dyx = XW'(dy_r) <<< 12;
    hx  = signed'(XW'(root_nx));
    xs  = cx >>> it;
    ys  = cy >>> it;
    at  = signed'(ZW'(ssjf_pkg::atan_q30(it)));

    // round and clamp the angle
    rr = cz + RND;
    rs = rr >>> SH;
    if (rr < 0) begin
      ang_fin = '0;
    end else if (rs > AMAX_CL) begin
      ang_fin = AMAX_CL[14:0];
    end else begin
      ang_fin = rs[14:0];
    end

    // stillness run decision
    run_len = (still_frames == 8'd0) ? 8'd1 : still_frames;
    if (!still_all) begin
      sc_inc = 8'd0;
    end else if (still_count == 8'hFF) begin
      sc_inc = 8'hFF;
    end else begin
      sc_inc = still_count + 8'd1;
    end
    hit    = (sc_inc == run_len);
    obs_nx = (obs == 16'hFFFF) ? obs : obs + 16'd1;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      thr          <= 10'd5;
      thr2         <= 20'd25;
      still_frames <= 8'd20;
      still_count  <= 8'd0;
      capturing    <= 1'b0;
      obs          <= 16'd0;
      out_valid    <= 1'b0;
      for (int n = 0; n < 12; n++) begin
        prev[n] <= '0;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: begin
            thr  <= cfg_data;
            thr2 <= cfg_data * cfg_data;
          end
          REG_STILL: still_frames <= cfg_data[7:0];
          default: ;
        endcase
      end

      // drop the output once transferred, unless a new result replaces it
      if (out_valid && out_ready && state != S_PUSH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur[0]  <= sat_coord(left_hand_x);
            cur[1]  <= sat_coord(left_hand_y);
            cur[2]  <= sat_coord(left_hand_z);
            cur[3]  <= sat_coord(left_elbow_x);
            cur[4]  <= sat_coord(left_elbow_y);
            cur[5]  <= sat_coord(left_elbow_z);
            cur[6]  <= sat_coord(right_hand_x);
            cur[7]  <= sat_coord(right_hand_y);
            cur[8]  <= sat_coord(right_hand_z);
            cur[9]  <= sat_coord(right_elbow_x);
            cur[10] <= sat_coord(right_elbow_y);
            cur[11] <= sat_coord(right_elbow_z);
            still_all <= (thr != 10'd0);
            k <= 2'd0;
            j <= 2'd0;
            state <= S_ST_MUL;
          end
        end

        S_ST_MUL: begin
          prod  <= sq_full[SQW-1:0];
          state <= S_ST_ACC;
        end

        // accumulate movement, rotate the frame and replace previous positions
        S_ST_ACC: begin
          for (int n = 0; n < 11; n++) begin
            cur[n]  <= cur[n+1];
            prev[n] <= prev[n+1];
          end
          cur[11]  <= cur[0];
          prev[11] <= cur[0];
          case (k)
            2'd0: acc_h <= HW'(prod);
            2'd1: dysq  <= prod;
            default: begin
              if (!(sum_s < SW'(thr2))) begin
                still_all <= 1'b0;
              end
            end
          endcase
          if (k == 2'd2) begin
            k <= 2'd0;
            j <= j + 2'd1;
            state <= (j == 2'd3) ? S_DECIDE : S_ST_MUL;
          end else begin
            k <= k + 2'd1;
            state <= S_ST_MUL;
          end
        end

        S_DECIDE: begin
          if (!capturing) begin
            still_count <= hit ? 8'd0 : sc_inc;
            capturing   <= hit;
            state       <= S_IDLE;
          end else begin
            if (obs == 16'd0) begin
              for (int n = 0; n < 12; n++) begin
                start[n] <= cur[n];
              end
            end
            idx_r <= obs_nx;
            end_r <= hit;
            if (hit) begin
              still_count <= 8'd0;
              capturing   <= 1'b0;
              obs         <= 16'd0;
            end else begin
              still_count <= sc_inc;
              obs         <= obs_nx;
            end
            j <= 2'd0;
            k <= 2'd0;
            state <= S_FE_MUL;
          end
        end

        S_FE_MUL: begin
          prod  <= sq_full[SQW-1:0];
          dcur  <= d_sel;
          state <= S_FE_ACC;
        end

        // accumulate offsets from the start pose, then launch the distance root
        S_FE_ACC: begin
          for (int n = 0; n < 11; n++) begin
            cur[n]   <= cur[n+1];
            start[n] <= start[n+1];
          end
          cur[11]   <= cur[0];
          start[11] <= start[0];
          case (k)
            2'd0: acc_h <= HW'(prod);
            2'd1: begin
              dysq <= prod;
              dy_r <= dcur;
            end
            default: begin
              h2_r <= h2_nx;
              opnd <= QW'(sum_s);
              rem  <= '0;
              root <= '0;
              rcnt <= '0;
            end
          endcase
          if (k == 2'd2) begin
            k <= 2'd0;
            state <= S_RT_D;
          end else begin
            k <= k + 2'd1;
            state <= S_FE_MUL;
          end
        end

        S_RT_D: begin
          if (rcnt == RCW'(RW - 1)) begin
            dist_r[j] <= dist_sat;
            opnd <= QW'({h2_r, 24'd0});
            rem  <= '0;
            root <= '0;
            rcnt <= '0;
            state <= S_RT_H;
          end else begin
            opnd <= opnd << 2;
            rem  <= rem_nx;
            root <= root_nx;
            rcnt <= rcnt + RCW'(1);
          end
        end

        // horizontal root, then set up the vectoring
        S_RT_H: begin
          opnd <= opnd << 2;
          rem  <= rem_nx;
          root <= root_nx;
          rcnt <= rcnt + RCW'(1);
          if (rcnt == RCW'(RW - 1)) begin
            it <= 5'd0;
            if (dy_r == '0 && h2_r == '0) begin
              ang_r[j] <= '0;
              j <= j + 2'd1;
              state <= (j == 2'd3) ? S_PUSH : S_FE_MUL;
            end else if (dyx < 0) begin
              cx <= hx;
              cy <= -dyx;
              cz <= ssjf_pkg::Q30_HALF_PI;
              state <= S_CORDIC;
            end else begin
              cx <= dyx;
              cy <= hx;
              cz <= '0;
              state <= S_CORDIC;
            end
          end
        end

        S_CORDIC: begin
          if (cy == '0) begin
            state <= S_ANG;
          end else begin
            if (cy > 0) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + at;
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - at;
            end
            it <= it + 5'd1;
            if (it == 5'd30) begin
              state <= S_ANG;
            end
          end
        end

        S_ANG: begin
          ang_r[j] <= ang_fin;
          j <= j + 2'd1;
          state <= (j == 2'd3) ? S_PUSH : S_FE_MUL;
        end

        // hand the result to the output register once it is free
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            for (int n = 0; n < 4; n++) begin
              od[n] <= dist_r[n];
              oa[n] <= ang_r[n];
            end
            observation_index <= idx_r;
            gesture_end       <= end_r;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign left_hand_distance   = od[0];
  assign left_elbow_distance  = od[1];
  assign right_hand_distance  = od[2];
  assign right_elbow_distance = od[3];
  assign left_hand_angle      = oa[0];
  assign left_elbow_angle     = oa[1];
  assign right_hand_angle     = oa[2];
  assign right_elbow_angle    = oa[3];

endmodule

// File: rtl/ssjf_chk.sv
// Port checker for the feature extractor, bound to the top level
module ssjf_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] left_hand_distance,
  input logic [15:0] observation_index
);

`include "stillness_segmented_joint_features_assert.svh"

  // a pending result holds until transferred
  `SSJF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SSJF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(left_hand_distance) && $stable(observation_index))
  // a result always carries a position within the gesture
  `SSJF_ASSERT_NOW(a_index_nonzero, out_valid, observation_index != 16'd0)
  // a frame keeps the block busy after it is taken
  `SSJF_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

bind stillness_segmented_joint_features ssjf_chk u_ssjf_chk (.*);
